/* hw/rtl/point_table_nearest_search_defines.svh */
// assertion macros used by the point table search top level
`ifndef POINT_TABLE_NEAREST_SEARCH_DEFINES_SVH
`define POINT_TABLE_NEAREST_SEARCH_DEFINES_SVH

// same-cycle implication, checked on every rising clock outside reset
`define PTNS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock outside reset
`define PTNS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ptns_pkg.sv */
// types, constants and helpers for the point table nearest search
`timescale 1ns / 1ps
`default_nettype none
package ptns_pkg;

   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CAP_W      = 9;
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int SLOT_W     = 8;
   localparam int COORD_W    = 32;
   localparam int KEY_W      = 64;
   localparam int DIST_W     = 2 * COORD_W + 1;
   localparam int CAP_RESET  = 256;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_DUP   = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   typedef struct packed {
      logic                      opcode;
      logic [KEY_W-1:0]          point_key;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [SLOT_W-1:0]         slot_index;
      logic [KEY_W-1:0]          found_key;
      logic signed [COORD_W-1:0] found_x;
      logic signed [COORD_W-1:0] found_y;
   } rsp_type;

   // one table entry as held in the point memory
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } ent_type;

   typedef struct packed {
      logic                      valid;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
   } dist_in_type;

   typedef struct packed {
      logic              valid;
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] sq_dist;
   } dist_out_type;

   // low bits of a slot number as reported on the result
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = (IDX_W + SLOT_W)'(idx);
      return wide[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/ptns_ram.sv */
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ptns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/ptns_dist.sv */
// three-stage squared euclidean distance pipeline
`timescale 1ns / 1ps
`default_nettype none
module ptns_dist (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire ptns_pkg::dist_in_type                dist_in,
   input  wire logic signed [ptns_pkg::COORD_W-1:0]  qry_x,
   input  wire logic signed [ptns_pkg::COORD_W-1:0]  qry_y,
   output      ptns_pkg::dist_out_type               dist_out,
   output      logic                                 busy
);
   import ptns_pkg::*;

   // stage 1: absolute differences
   logic                 s1_vld_ff, s1_vld_in;
   logic [IDX_W-1:0]     s1_idx_ff, s1_idx_in;
   logic [COORD_W-1:0]   s1_ax_ff, s1_ax_in;
   logic [COORD_W-1:0]   s1_ay_ff, s1_ay_in;
   // stage 2: squares
   logic                 s2_vld_ff, s2_vld_in;
   logic [IDX_W-1:0]     s2_idx_ff, s2_idx_in;
   logic [2*COORD_W-1:0] s2_sx_ff, s2_sx_in;
   logic [2*COORD_W-1:0] s2_sy_ff, s2_sy_in;
   // stage 3: sum
   dist_out_type         s3_ff, s3_in;

   logic [COORD_W:0] dx, dy, ndx, ndy;

   always_comb begin
      dx  = {dist_in.px[COORD_W-1], dist_in.px} - {qry_x[COORD_W-1], qry_x};
      dy  = {dist_in.py[COORD_W-1], dist_in.py} - {qry_y[COORD_W-1], qry_y};
      ndx = -dx;
      ndy = -dy;

      s1_vld_in = dist_in.valid;
      s1_idx_in = dist_in.idx;
      s1_ax_in  = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
      s1_ay_in  = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];

      s2_vld_in = s1_vld_ff;
      s2_idx_in = s1_idx_ff;
      s2_sx_in  = (2 * COORD_W)'(s1_ax_ff) * (2 * COORD_W)'(s1_ax_ff);
      s2_sy_in  = (2 * COORD_W)'(s1_ay_ff) * (2 * COORD_W)'(s1_ay_ff);

      s3_in.valid   = s2_vld_ff;
      s3_in.idx     = s2_idx_ff;
      s3_in.sq_dist = {1'b0, s2_sx_ff} + {1'b0, s2_sy_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else begin
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         s3_ff.valid <= s3_in.valid;
      end
      s1_idx_ff     <= s1_idx_in;
      s1_ax_ff      <= s1_ax_in;
      s1_ay_ff      <= s1_ay_in;
      s2_idx_ff     <= s2_idx_in;
      s2_sx_ff      <= s2_sx_in;
      s2_sy_ff      <= s2_sy_in;
      s3_ff.idx     <= s3_in.idx;
      s3_ff.sq_dist <= s3_in.sq_dist;
   end

   assign dist_out = s3_ff;
   assign busy     = s1_vld_ff | s2_vld_ff | s3_ff.valid;

endmodule
`default_nettype wire

/* hw/rtl/point_table_nearest_search.sv */
// top level of the keyed 2-d point table with nearest-point search
// Keyed point table with brute-force nearest search. Points (64-bit key,
// signed Q16.16 x and y) live in one 128-bit wide memory of MAX_POINTS
// entries with a registered read. Every item gives one result beat.
// An insert is refused at once (status full) when the stored count has
// reached the smaller of the capacity register and MAX_POINTS; otherwise all
// stored keys are read back one per cycle, the first equal key gives status
// duplicate with its slot, and a new key is written to the next slot. A query
// reads all stored points one per cycle through a three-stage squared
// distance pipeline (exact 65-bit result), keeps the first strict minimum,
// then reads the winning entry back once more. A query on an empty table
// answers status empty at once. A scanned item answers after its scan, the
// read latency and the pipeline drain, and a query also after the winner
// read back; the scan is paced by the single memory read port. A result
// waits while the previous beat still stalls in the output register. One
// item is worked on at a time; the next can be taken in the same cycle that
// its result shows, while that result still sits in the output register.
// Write capacity only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "point_table_nearest_search_defines.svh"
module point_table_nearest_search (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // item channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire ptns_pkg::req_type             req_data,
   // result channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      ptns_pkg::rsp_type             rsp_data,
   // capacity register write
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [ptns_pkg::CAP_W-1:0]    csr_data
);
   import ptns_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_LOAD  = 5'b01000,
      S_REPLY = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   // read issued last cycle, data on the ram output now
   logic              rdv_ff, rdv_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   // first duplicate key seen by an insert scan
   logic              match_ff, match_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   // running minimum of a query scan
   logic              best_vld_ff, best_vld_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   // finished result waiting for the output register
   rsp_type           res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // memory port
   logic              ram_re, ram_we;
   logic [IDX_W-1:0]  ram_raddr, ram_waddr;
   ent_type           ram_wdata, ram_rdata;

   // distance pipeline
   dist_in_type       dist_in;
   dist_out_type      dist_out;
   logic              dist_busy;

   logic              accept;
   logic              full;
   logic              scan_rd;
   logic              dup_hit;
   logic              drained;

   ptns_ram #(
      .WIDTH ($bits(ent_type)),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptns_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .dist_in  (dist_in),
      .qry_x    (item_ff.pos_x),
      .qry_y    (item_ff.pos_y),
      .dist_out (dist_out),
      .busy     (dist_busy)
   );

   // one item in flight; a pending result does not block the input
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // table full against both the register and the built depth
   assign full    = (CMP_W'(count_ff) >= CMP_W'(cap_ff))
                 || (count_ff >= CNT_W'(MAX_POINTS));
   assign scan_rd = (state_ff == S_SCAN) && (addr_ff != count_ff);
   assign dup_hit = rdv_ff && (item_ff.opcode == OP_INSERT)
                 && (ram_rdata.key == item_ff.point_key);
   assign drained = !rdv_ff && !dist_busy;

   // stored points feed the distance pipeline only for queries
   always_comb begin
      dist_in.valid = rdv_ff && (item_ff.opcode == OP_QUERY);
      dist_in.idx   = rd_idx_ff;
      dist_in.px    = ram_rdata.x;
      dist_in.py    = ram_rdata.y;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      addr_in      = addr_ff;
      rdv_in       = scan_rd;
      rd_idx_in    = addr_ff[IDX_W-1:0];
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      best_vld_in  = best_vld_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      ram_re    = 1'b0;
      ram_raddr = addr_ff[IDX_W-1:0];
      ram_we    = 1'b0;
      ram_waddr = count_ff[IDX_W-1:0];
      ram_wdata = {item_ff.point_key, item_ff.pos_x, item_ff.pos_y};

      if (csr_valid) begin
         cap_in = csr_data;
      end

      // output register drains when the beat is taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // earliest equal key wins
      if (dup_hit && !match_ff) begin
         match_in     = 1'b1;
         match_idx_in = rd_idx_ff;
      end

      // strict less keeps the lowest slot on ties
      if (dist_out.valid && (!best_vld_ff || (dist_out.sq_dist < best_dist_ff))) begin
         best_vld_in  = 1'b1;
         best_idx_in  = dist_out.idx;
         best_dist_in = dist_out.sq_dist;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in     = req_data;
               addr_in     = '0;
               match_in    = 1'b0;
               best_vld_in = 1'b0;
               res_in      = '0;
               if ((req_data.opcode == OP_INSERT) && full) begin
                  res_in.status = STAT_FULL;
                  state_in      = S_REPLY;
               end else if ((req_data.opcode == OP_QUERY) && (count_ff == '0)) begin
                  res_in.status = STAT_EMPTY;
                  state_in      = S_REPLY;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // one stored entry read per cycle
            if (scan_rd) begin
               ram_re  = 1'b1;
               addr_in = addr_ff + CNT_W'(1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (drained) begin
               res_in = '0;
               if (item_ff.opcode == OP_INSERT) begin
                  if (match_ff) begin
                     res_in.status     = STAT_DUP;
                     res_in.slot_index = to_slot(match_idx_ff);
                  end else begin
                     ram_we            = 1'b1;
                     count_in          = count_ff + CNT_W'(1);
                     res_in.status     = STAT_OK;
                     res_in.slot_index = to_slot(count_ff[IDX_W-1:0]);
                  end
                  state_in = S_REPLY;
               end else begin
                  // read the winner back for its key and coordinates
                  ram_re    = 1'b1;
                  ram_raddr = best_idx_ff;
                  state_in  = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            res_in.status     = STAT_OK;
            res_in.slot_index = to_slot(best_idx_ff);
            res_in.found_key  = ram_rdata.key;
            res_in.found_x    = ram_rdata.x;
            res_in.found_y    = ram_rdata.y;
            state_in          = S_REPLY;
         end
         S_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_W'(CAP_RESET);
         addr_ff      <= '0;
         rdv_ff       <= 1'b0;
         match_ff     <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         addr_ff      <= addr_in;
         rdv_ff       <= rdv_in;
         match_ff     <= match_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      rd_idx_ff    <= rd_idx_in;
      match_idx_ff <= match_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no table write while scan reads are still in flight
   `PTNS_ASSERT_IMP(a_wr_quiet, clock, reset, ram_we, !rdv_ff && !dist_busy, "write during scan")
   // each table write grows the count by exactly one
   `PTNS_ASSERT_NEXT(a_cnt_step, clock, reset, ram_we, count_ff == $past(count_ff) + CNT_W'(1), "count step")
   // distances only flow for query items
   `PTNS_ASSERT_IMP(a_dist_query, clock, reset, dist_out.valid, item_ff.opcode == OP_QUERY, "distance on insert")
   // an accepted item leaves the idle state
   `PTNS_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != S_IDLE, "idle after accept")
   // a new result beat comes only out of the reply state
   `PTNS_ASSERT_IMP(a_rsp_src, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_REPLY, "stray result")

endmodule
`default_nettype wire

/* sim/tb.sv */
// self-checking testbench for point_table_nearest_search with its scoreboard class
`timescale 1ns / 1ps

// mirror of the point table: predicts the result of every accepted beat
class point_table_tracker;
   logic [ptns_pkg::KEY_W-1:0]          keys [ptns_pkg::MAX_POINTS];
   logic signed [ptns_pkg::COORD_W-1:0] xs   [ptns_pkg::MAX_POINTS];
   logic signed [ptns_pkg::COORD_W-1:0] ys   [ptns_pkg::MAX_POINTS];
   int unsigned                         count = 0;
   int unsigned                         capacity = ptns_pkg::CAP_RESET;
   ptns_pkg::rsp_type                   expected_answers [$];
   int                                  mismatches = 0;

   // works out the answer to one accepted item and queues it
   function void take_item(ptns_pkg::req_type item);
      ptns_pkg::rsp_type answer;
      int unsigned       limit;
      int unsigned       best;
      int unsigned       i;
      longint            dx;
      longint            dy;
      logic [65:0]       span;
      logic [65:0]       best_span;
      answer = '0;
      best = count;
      best_span = '0;
      if (item.opcode == ptns_pkg::OP_INSERT) begin
         limit = (capacity < ptns_pkg::MAX_POINTS) ? capacity : ptns_pkg::MAX_POINTS;
         if (count >= limit) begin
            // full wins over duplicate
            answer.status = ptns_pkg::STAT_FULL;
         end else begin
            for (i = 0; i < count; i++) begin
               if (best == count && keys[i] == item.point_key) best = i;
            end
            answer.slot_index = ptns_pkg::SLOT_W'(best);
            if (best < count) begin
               answer.status = ptns_pkg::STAT_DUP;
            end else begin
               answer.status = ptns_pkg::STAT_OK;
               keys[count] = item.point_key;
               xs[count] = item.pos_x;
               ys[count] = item.pos_y;
               count++;
            end
         end
      end else if (count == 0) begin
         answer.status = ptns_pkg::STAT_EMPTY;
      end else begin
         // exact squared distance, first strict minimum wins
         for (i = 0; i < count; i++) begin
            dx = longint'($signed(xs[i])) - longint'($signed(item.pos_x));
            dy = longint'($signed(ys[i])) - longint'($signed(item.pos_y));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            span = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
            if (i == 0 || span < best_span) begin
               best = i;
               best_span = span;
            end
         end
         answer.status = ptns_pkg::STAT_OK;
         answer.slot_index = ptns_pkg::SLOT_W'(best);
         answer.found_key = keys[best];
         answer.found_x = xs[best];
         answer.found_y = ys[best];
      end
      expected_answers.push_back(answer);
   endfunction

   // compares one result beat with the oldest queued answer
   function void compare_answer(ptns_pkg::rsp_type got);
      ptns_pkg::rsp_type want;
      if (expected_answers.size() == 0) begin
         $display("%0t: result beat with nothing outstanding, got %h", $time, got);
         mismatches++;
         return;
      end
      want = expected_answers.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         mismatches++;
      end
      if (got.slot_index !== want.slot_index) begin
         $display("%0t: slot_index expected %0d got %0d", $time, want.slot_index,
                  got.slot_index);
         mismatches++;
      end
      if (got.found_key !== want.found_key) begin
         $display("%0t: found_key expected %h got %h", $time, want.found_key, got.found_key);
         mismatches++;
      end
      if (got.found_x !== want.found_x) begin
         $display("%0t: found_x expected %h got %h", $time, want.found_x, got.found_x);
         mismatches++;
      end
      if (got.found_y !== want.found_y) begin
         $display("%0t: found_y expected %h got %h", $time, want.found_y, got.found_y);
         mismatches++;
      end
   endfunction
endclass

module tb;
   import ptns_pkg::*;

   // cycles with no beat on any channel before the run is called hung
   localparam int WATCHDOG_LIMIT = 5000;
   // one full scan of the table plus margin, to catch stray result beats
   localparam int TAIL_CYCLES = 300;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
   localparam logic signed [COORD_W-1:0] CORNERS [4] =
      '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff};

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data;

   point_table_tracker board = new;
   // remaining beats of a no-idle stretch, one per side
   int               send_calm = 0;
   int               recv_calm = 0;
   int               idle_cycles = 0;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   point_table_nearest_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // random idle gap before the next beat, with runs of back-to-back beats
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 10);
   endfunction

   function automatic req_type make_item(input logic op, input logic [KEY_W-1:0] key,
                                         input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y);
      req_type item;
      item.opcode = op;
      item.point_key = key;
      item.pos_x = x;
      item.pos_y = y;
      return item;
   endfunction

   // random item biased toward stored keys and positions
   function automatic req_type pick_item();
      req_type     item;
      int unsigned pick;
      int unsigned slot;
      item.opcode = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_QUERY;
      item.point_key = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick < 2 && board.count > 0) begin
         // key already in the table
         item.point_key = board.keys[$urandom_range(0, board.count - 1)];
      end else if (pick == 2) begin
         // tiny key space, repeats often
         item.point_key = 64'($urandom_range(0, 7));
      end
      item.pos_x = $urandom;
      item.pos_y = $urandom;
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
         // a few units around the origin, many equal distances
         item.pos_x = 32'($urandom_range(0, 'h4_0000)) - 32'h2_0000;
         item.pos_y = 32'($urandom_range(0, 'h4_0000)) - 32'h2_0000;
      end else if (pick < 4 && board.count > 0) begin
         // on or next to a stored point: exact hits and shared positions
         slot = $urandom_range(0, board.count - 1);
         item.pos_x = board.xs[slot] + 32'($urandom_range(0, 2)) - 32'd1;
         item.pos_y = board.ys[slot];
      end else if (pick == 4) begin
         item.pos_x = CORNERS[$urandom_range(0, 3)];
         item.pos_y = CORNERS[$urandom_range(0, 3)];
      end
      return item;
   endfunction

   // one beat on the item channel, returns at the accepting edge
   task automatic send_item(input req_type item);
      int gap;
      gap = draw_wait(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // capacity write once every outstanding result has come back
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      // at least one edge so the last accepted item is already queued
      do @(posedge clock); while (board.expected_answers.size() != 0);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      board.capacity = value;
   endtask

   task automatic run_random(input int beats);
      repeat (beats) send_item(pick_item());
   endtask

   // both channels observed at the edge, before any update of that edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_item(req_data);
         if (rsp_valid && !rsp_stall) board.compare_answer(rsp_data);
      end
   end

   // hang detector: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stall each beat for a drawn number of cycles once it shows up
   initial begin
      int hold;
      forever begin
         hold = draw_wait(recv_calm);
         rsp_stall <= (hold > 0);
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (hold > 0) begin
            repeat (hold - 1) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // query before anything is stored
      send_item(make_item(OP_QUERY, 64'h0, C_MIN, C_MAX));

      // zero capacity refuses even the first insert
      write_capacity(9'd0);
      send_item(make_item(OP_INSERT, 64'h0, 32'sd0, 32'sd0));

      // one point allowed: full, and full with a duplicate key
      write_capacity(9'd1);
      send_item(make_item(OP_INSERT, '1, C_MIN, C_MIN));
      send_item(make_item(OP_INSERT, '1, 32'sd0, 32'sd0));
      send_item(make_item(OP_INSERT, 64'h1234, 32'sd5, 32'sd5));
      // distance above 64 bits
      send_item(make_item(OP_QUERY, 64'hdead_beef_0000_0001, C_MAX, C_MAX));

      // capacity above the table depth, limit is the depth
      write_capacity(9'h1ff);
      send_item(make_item(OP_INSERT, '1, 32'sd1, 32'sd1));
      send_item(make_item(OP_INSERT, 64'h8000_0000_0000_0000, C_MIN + 32'sd1, C_MIN));
      // both candidates past 2^64, the low part decides
      send_item(make_item(OP_QUERY, '1, C_MAX, C_MAX));
      send_item(make_item(OP_INSERT, 64'h0, C_MAX, C_MAX));
      send_item(make_item(OP_INSERT, 64'h5, C_MIN, C_MAX));
      send_item(make_item(OP_INSERT, 64'h6, C_MAX, C_MIN));
      send_item(make_item(OP_QUERY, 64'h0, 32'sd0, 32'sd0));
      // two keys on one position: the earlier slot wins ties
      send_item(make_item(OP_INSERT, 64'h7, 32'sd0, 32'sd0));
      send_item(make_item(OP_INSERT, 64'h8, 32'sd0, 32'sd0));
      send_item(make_item(OP_QUERY, 64'h0, 32'sd0, 32'sd0));
      send_item(make_item(OP_INSERT, 64'h9, 32'sd2, 32'sd0));
      // three points at distance one
      send_item(make_item(OP_QUERY, 64'h0, 32'sd1, 32'sd0));
      send_item(make_item(OP_QUERY, 64'h5555_aaaa_5555_aaaa, C_MIN, C_MAX));
      send_item(make_item(OP_QUERY, 64'haaaa_5555_aaaa_5555, 32'shffff_ffff,
                          32'shffff_ffff));

      // small table that fills early
      write_capacity(9'($urandom_range(20, 60)));
      run_random(250);
      // capacity below the stored count: inserts refused, queries still served
      write_capacity(9'd3);
      run_random(150);
      // full depth, table fills up to the last slot
      write_capacity(9'd256);
      run_random(1100);
      write_capacity(9'h1ff);
      run_random(100);

      // drain, then give stray beats time to show
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_answers.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
